// ----- rtl/core/xdr_pkg.sv -----
// ----------------------------------------------------------------------------
// xdr_pkg
// Shared types and codes for the XML declaration recognizer.
// ----------------------------------------------------------------------------
package xdr_pkg;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned OFS_W = 16;
  localparam int unsigned ST_W  = 4;
  localparam int unsigned SD_W  = 2;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK        = 4'd0;
  localparam logic [ST_W-1:0] ST_SPACE     = 4'd1;
  localparam logic [ST_W-1:0] ST_VER_MISS  = 4'd2;
  localparam logic [ST_W-1:0] ST_VER_NUM   = 4'd3;
  localparam logic [ST_W-1:0] ST_ENC_MISS  = 4'd4;
  localparam logic [ST_W-1:0] ST_ENC_NAME  = 4'd5;
  localparam logic [ST_W-1:0] ST_SD_VALUE  = 4'd6;
  localparam logic [ST_W-1:0] ST_SD_TEXT   = 4'd7;
  localparam logic [ST_W-1:0] ST_EQ        = 4'd8;
  localparam logic [ST_W-1:0] ST_QUOTE     = 4'd9;
  localparam logic [ST_W-1:0] ST_COMPONENT = 4'd10;
  localparam logic [ST_W-1:0] ST_UNTERM    = 4'd11;
  localparam logic [ST_W-1:0] ST_CHAR      = 4'd12;
  localparam logic [ST_W-1:0] ST_NOT_DECL  = 4'd13;

  // Standalone values.
  localparam logic [SD_W-1:0] SD_ABSENT = 2'd0;
  localparam logic [SD_W-1:0] SD_YES    = 2'd1;
  localparam logic [SD_W-1:0] SD_NO     = 2'd2;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            end_of_input;
    logic            char_fault;
  } item_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [OFS_W-1:0] version_start;
    logic [OFS_W-1:0] version_span;
    logic [OFS_W-1:0] encoding_start;
    logic [OFS_W-1:0] encoding_span;
    logic [SD_W-1:0]  standalone_value;
    logic [OFS_W-1:0] decl_length;
    logic             length_overflow;
  } result_t;

endpackage

// ----- rtl/core/xdr_in_reg.sv -----
// ----------------------------------------------------------------------------
// xdr_in_reg
// Input register: holds one accepted character until the parser consumes it.
// ----------------------------------------------------------------------------
module xdr_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  xdr_pkg::item_t in_item_i,
  input  logic          consume_i,
  output logic          item_valid_o,
  output xdr_pkg::item_t item_o
);

  logic           valid_q, valid_d;
  logic           accept;
  xdr_pkg::item_t item_q;

  assign in_stall_o = valid_q & ~consume_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign valid_d    = accept | (valid_q & ~consume_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ----- rtl/core/xdr_parse.sv -----
// ----------------------------------------------------------------------------
// xdr_parse
// Declaration state machine: one character transition per cycle unless held
// by a full output register; result formed combinationally for that register.
// ----------------------------------------------------------------------------
module xdr_parse #(
  parameter int unsigned POS_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_text_mode_i,
  input  logic              item_valid_i,
  input  xdr_pkg::item_t    item_i,
  input  logic              out_free_i,
  output logic              step_o,
  output logic              emit_o,
  output xdr_pkg::result_t  result_o
);

  localparam int unsigned PH_W = 4;
  localparam logic [PH_W-1:0] PH_OPEN   = 4'd0;
  localparam logic [PH_W-1:0] PH_HEAD   = 4'd1;
  localparam logic [PH_W-1:0] PH_KEY    = 4'd2;
  localparam logic [PH_W-1:0] PH_EQ1    = 4'd3;
  localparam logic [PH_W-1:0] PH_EQ2    = 4'd4;
  localparam logic [PH_W-1:0] PH_VER1   = 4'd5;
  localparam logic [PH_W-1:0] PH_VERDOT = 4'd6;
  localparam logic [PH_W-1:0] PH_VERDIG = 4'd7;
  localparam logic [PH_W-1:0] PH_ENC1   = 4'd8;
  localparam logic [PH_W-1:0] PH_ENCN   = 4'd9;
  localparam logic [PH_W-1:0] PH_SD1    = 4'd10;
  localparam logic [PH_W-1:0] PH_SDLIT  = 4'd11;
  localparam logic [PH_W-1:0] PH_SDQ    = 4'd12;

  localparam logic [2:0] KW_END = 3'd0;
  localparam logic [2:0] KW_VER = 3'd1;
  localparam logic [2:0] KW_ENC = 3'd2;
  localparam logic [2:0] KW_SD  = 3'd3;
  localparam logic [2:0] KW_YES = 3'd4;
  localparam logic [2:0] KW_NO  = 3'd5;

  localparam logic [0:4][7:0] OPEN_LIT = "<?xml";
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  localparam logic [7:0] CH_QM    = 8'h3F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ONE   = 8'h31;

  function automatic logic [7:0] kw_char(logic [2:0] sel, logic [3:0] idx);
    logic [0:9][7:0] row;
    begin
      case (sel)
        KW_END:  row = {"?>", 64'h0};
        KW_VER:  row = {"version", 24'h0};
        KW_ENC:  row = {"encoding", 16'h0};
        KW_SD:   row = "standalone";
        KW_YES:  row = {"yes", 56'h0};
        KW_NO:   row = {"no", 64'h0};
        default: row = '0;
      endcase
      kw_char = (idx <= 4'd9) ? row[idx] : 8'h00;
    end
  endfunction

  function automatic logic [3:0] kw_len(logic [2:0] sel);
    begin
      case (sel)
        KW_END:  kw_len = 4'd2;
        KW_VER:  kw_len = 4'd7;
        KW_ENC:  kw_len = 4'd8;
        KW_SD:   kw_len = 4'd10;
        KW_YES:  kw_len = 4'd3;
        KW_NO:   kw_len = 4'd2;
        default: kw_len = 4'd0;
      endcase
    end
  endfunction

  function automatic logic ch_eq(logic [xdr_pkg::CP_W-1:0] c, logic [7:0] ch);
    begin
      ch_eq = (c == xdr_pkg::CP_W'(ch));
    end
  endfunction

  function automatic logic is_space(logic [xdr_pkg::CP_W-1:0] c);
    begin
      is_space = ch_eq(c, 8'h20) || ch_eq(c, 8'h09) || ch_eq(c, 8'h0D) || ch_eq(c, 8'h0A);
    end
  endfunction

  function automatic logic is_latin(logic [xdr_pkg::CP_W-1:0] c);
    begin
      is_latin = (c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A);
    end
  endfunction

  function automatic logic is_digit(logic [xdr_pkg::CP_W-1:0] c);
    begin
      is_digit = (c >= 21'h30 && c <= 21'h39);
    end
  endfunction

  function automatic logic is_enc_char(logic [xdr_pkg::CP_W-1:0] c);
    begin
      is_enc_char = is_latin(c) || is_digit(c) || ch_eq(c, CH_DOT)
                    || ch_eq(c, 8'h5F) || ch_eq(c, 8'h2D);
    end
  endfunction

  logic                text_mode_q;
  logic [PH_W-1:0]     phase_q, phase_d;
  logic [1:0]          stage_q, stage_d;
  logic [2:0]          kw_sel_q, kw_sel_d;
  logic [3:0]          match_q, match_d;
  logic                space_q, space_d;
  logic                quote_dbl_q, quote_dbl_d;
  logic                digit_q, digit_d;
  logic                ovf_q, ovf_d;
  logic                ver_pres_q, ver_pres_d;
  logic                enc_pres_q, enc_pres_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [POS_BITS-1:0] ver_start_q, ver_start_d;
  logic [POS_BITS-1:0] ver_len_q, ver_len_d;
  logic [POS_BITS-1:0] enc_start_q, enc_start_d;
  logic [POS_BITS-1:0] enc_len_q, enc_len_d;
  logic [1:0]          sd_q, sd_d;

  logic                   emit, clear;
  logic [xdr_pkg::ST_W-1:0] status;
  logic [POS_BITS-1:0]    pos_next;
  logic                   ovf_next;
  logic [xdr_pkg::CP_W-1:0] c;
  logic                   eof, flt, plain;
  logic [7:0]             quote;
  logic [2:0]             sel;
  logic [3:0]             match_inc;
  logic                   ok;

  always_comb begin
    c         = item_i.code_point;
    eof       = item_i.end_of_input;
    flt       = item_i.char_fault;
    plain     = ~eof & ~flt;
    quote     = quote_dbl_q ? CH_DQ : CH_SQ;
    sel       = (kw_sel_q < 3'd6) ? kw_sel_q : KW_END;
    match_inc = match_q + 4'd1;

    pos_next = (pos_q != POS_MAX) ? pos_q + 1'b1 : pos_q;
    ovf_next = ovf_q | (pos_q == POS_MAX);

    phase_d     = phase_q;
    stage_d     = stage_q;
    kw_sel_d    = kw_sel_q;
    match_d     = match_q;
    space_d     = space_q;
    quote_dbl_d = quote_dbl_q;
    digit_d     = digit_q;
    ovf_d       = ovf_next;
    ver_pres_d  = ver_pres_q;
    enc_pres_d  = enc_pres_q;
    pos_d       = pos_next;
    ver_start_d = ver_start_q;
    ver_len_d   = ver_len_q;
    enc_start_d = enc_start_q;
    enc_len_d   = enc_len_q;
    sd_d        = sd_q;
    emit        = 1'b0;
    clear       = 1'b0;
    status      = xdr_pkg::ST_OK;

    case (phase_q)
      PH_OPEN: begin
        if (match_q < 4'd5) begin
          if (!plain || !ch_eq(c, OPEN_LIT[match_q[2:0]])) begin
            emit = 1'b1; status = xdr_pkg::ST_NOT_DECL;
          end else begin
            match_d = match_inc;
          end
        end else if (!plain || !is_space(c)) begin
          emit = 1'b1; status = xdr_pkg::ST_NOT_DECL;
        end else begin
          match_d = 4'd0;
          phase_d = PH_HEAD;
          space_d = 1'b1;
        end
      end
      PH_HEAD: begin
        if (flt) begin
          emit = 1'b1; status = xdr_pkg::ST_CHAR;
        end else if (eof) begin
          emit = 1'b1; status = xdr_pkg::ST_UNTERM;
        end else if (is_space(c)) begin
          space_d = 1'b1;
        end else begin
          phase_d = PH_KEY;
          match_d = 4'd1;
          if (ch_eq(c, CH_QM)) begin
            kw_sel_d = KW_END;
          end else if (ch_eq(c, 8'h76) && stage_q == 2'd0) begin
            kw_sel_d = KW_VER;
          end else if (ch_eq(c, 8'h65) && stage_q <= 2'd1) begin
            kw_sel_d = KW_ENC;
          end else if (ch_eq(c, 8'h73) && stage_q <= 2'd2) begin
            kw_sel_d = KW_SD;
          end else begin
            emit = 1'b1; status = xdr_pkg::ST_COMPONENT;
          end
        end
      end
      PH_KEY: begin
        if (sel > KW_SD || match_q >= kw_len(sel) || !plain
            || !ch_eq(c, kw_char(sel, match_q))) begin
          emit = 1'b1; status = xdr_pkg::ST_COMPONENT;
        end else if (match_inc < kw_len(sel)) begin
          match_d = match_inc;
        end else begin
          match_d = 4'd0;
          if (sel == KW_END) begin
            emit = 1'b1;
            if (!text_mode_q && !ver_pres_q) begin
              status = xdr_pkg::ST_VER_MISS;
            end else if (text_mode_q && !enc_pres_q) begin
              status = xdr_pkg::ST_ENC_MISS;
            end else begin
              status = xdr_pkg::ST_OK;
            end
          end else if (sel == KW_SD && text_mode_q) begin
            emit = 1'b1; status = xdr_pkg::ST_SD_TEXT;
          end else if (!space_q) begin
            emit = 1'b1; status = xdr_pkg::ST_SPACE;
          end else begin
            phase_d = PH_EQ1;
          end
        end
      end
      PH_EQ1: begin
        if (flt) begin
          emit = 1'b1; status = xdr_pkg::ST_CHAR;
        end else if (plain && is_space(c)) begin
          phase_d = PH_EQ1;
        end else if (!plain || !ch_eq(c, CH_EQ)) begin
          emit = 1'b1; status = xdr_pkg::ST_EQ;
        end else begin
          phase_d = PH_EQ2;
        end
      end
      PH_EQ2: begin
        if (flt) begin
          emit = 1'b1; status = xdr_pkg::ST_CHAR;
        end else if (plain && is_space(c)) begin
          phase_d = PH_EQ2;
        end else if (!plain || (!ch_eq(c, CH_DQ) && !ch_eq(c, CH_SQ))) begin
          emit = 1'b1; status = xdr_pkg::ST_QUOTE;
        end else begin
          quote_dbl_d = ch_eq(c, CH_DQ);
          // Value offsets point at the character after the opening quote.
          if (sel == KW_VER) begin
            ver_start_d = pos_next;
            phase_d     = PH_VER1;
          end else if (sel == KW_ENC) begin
            enc_start_d = pos_next;
            phase_d     = PH_ENC1;
          end else begin
            phase_d = PH_SD1;
          end
        end
      end
      PH_VER1: begin
        if (flt) begin
          emit = 1'b1; status = xdr_pkg::ST_CHAR;
        end else if (!plain || !ch_eq(c, CH_ONE)) begin
          emit = 1'b1; status = xdr_pkg::ST_VER_NUM;
        end else begin
          phase_d = PH_VERDOT;
        end
      end
      PH_VERDOT: begin
        if (flt) begin
          emit = 1'b1; status = xdr_pkg::ST_CHAR;
        end else if (!plain || !ch_eq(c, CH_DOT)) begin
          emit = 1'b1; status = xdr_pkg::ST_VER_NUM;
        end else begin
          digit_d = 1'b0;
          phase_d = PH_VERDIG;
        end
      end
      PH_VERDIG: begin
        if (flt) begin
          emit = 1'b1; status = xdr_pkg::ST_CHAR;
        end else if (plain && is_digit(c)) begin
          digit_d = 1'b1;
        end else if (!digit_q) begin
          emit = 1'b1; status = xdr_pkg::ST_VER_NUM;
        end else if (!plain || !ch_eq(c, quote)) begin
          emit = 1'b1; status = xdr_pkg::ST_QUOTE;
        end else begin
          ver_len_d  = pos_q - ver_start_q;
          ver_pres_d = 1'b1;
          stage_d    = 2'd1;
          space_d    = 1'b0;
          phase_d    = PH_HEAD;
        end
      end
      PH_ENC1: begin
        if (flt) begin
          emit = 1'b1; status = xdr_pkg::ST_CHAR;
        end else if (!plain || !is_latin(c)) begin
          emit = 1'b1; status = xdr_pkg::ST_ENC_NAME;
        end else begin
          phase_d = PH_ENCN;
        end
      end
      PH_ENCN: begin
        if (flt) begin
          emit = 1'b1; status = xdr_pkg::ST_CHAR;
        end else if (plain && is_enc_char(c)) begin
          phase_d = PH_ENCN;
        end else if (!plain || !ch_eq(c, quote)) begin
          emit = 1'b1; status = xdr_pkg::ST_QUOTE;
        end else begin
          enc_len_d  = pos_q - enc_start_q;
          enc_pres_d = 1'b1;
          stage_d    = 2'd2;
          space_d    = 1'b0;
          phase_d    = PH_HEAD;
        end
      end
      PH_SD1: begin
        if (plain && ch_eq(c, 8'h79)) begin
          kw_sel_d = KW_YES;
          match_d  = 4'd1;
          phase_d  = PH_SDLIT;
        end else if (plain && ch_eq(c, 8'h6E)) begin
          kw_sel_d = KW_NO;
          match_d  = 4'd1;
          phase_d  = PH_SDLIT;
        end else begin
          emit = 1'b1; status = xdr_pkg::ST_SD_VALUE;
        end
      end
      PH_SDLIT: begin
        if (sel < KW_YES || match_q >= kw_len(sel) || !plain
            || !ch_eq(c, kw_char(sel, match_q))) begin
          emit = 1'b1; status = xdr_pkg::ST_SD_VALUE;
        end else if (match_inc >= kw_len(sel)) begin
          match_d = 4'd0;
          phase_d = PH_SDQ;
        end else begin
          match_d = match_inc;
        end
      end
      PH_SDQ: begin
        if (flt) begin
          emit = 1'b1; status = xdr_pkg::ST_CHAR;
        end else if (!plain || !ch_eq(c, quote)) begin
          emit = 1'b1; status = xdr_pkg::ST_QUOTE;
        end else begin
          sd_d    = (sel == KW_YES) ? xdr_pkg::SD_YES : xdr_pkg::SD_NO;
          stage_d = 2'd3;
          space_d = 1'b0;
          phase_d = PH_HEAD;
        end
      end
      default: begin
        clear = 1'b1;
      end
    endcase

    // Every result, and any undefined phase code, returns to the idle state.
    if (emit || clear) begin
      phase_d     = PH_OPEN;
      stage_d     = 2'd0;
      kw_sel_d    = KW_END;
      match_d     = 4'd0;
      space_d     = 1'b0;
      quote_dbl_d = 1'b0;
      digit_d     = 1'b0;
      ovf_d       = 1'b0;
      ver_pres_d  = 1'b0;
      enc_pres_d  = 1'b0;
      pos_d       = '0;
      ver_start_d = '0;
      ver_len_d   = '0;
      enc_start_d = '0;
      enc_len_d   = '0;
      sd_d        = xdr_pkg::SD_ABSENT;
    end
  end

  assign ok     = (status == xdr_pkg::ST_OK);
  assign emit_o = item_valid_i & emit;
  assign step_o = item_valid_i & (~emit | out_free_i);

  always_comb begin
    result_o.status           = status;
    result_o.version_start    = ok ? xdr_pkg::OFS_W'(ver_start_q) : '0;
    result_o.version_span     = ok ? xdr_pkg::OFS_W'(ver_len_q) : '0;
    result_o.encoding_start   = ok ? xdr_pkg::OFS_W'(enc_start_q) : '0;
    result_o.encoding_span    = ok ? xdr_pkg::OFS_W'(enc_len_q) : '0;
    result_o.standalone_value = ok ? sd_q : xdr_pkg::SD_ABSENT;
    result_o.decl_length      = ok ? xdr_pkg::OFS_W'(pos_next) : '0;
    result_o.length_overflow  = ovf_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      text_mode_q <= cfg_text_mode_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_OPEN;
      stage_q     <= 2'd0;
      kw_sel_q    <= KW_END;
      match_q     <= 4'd0;
      space_q     <= 1'b0;
      quote_dbl_q <= 1'b0;
      digit_q     <= 1'b0;
      ovf_q       <= 1'b0;
      ver_pres_q  <= 1'b0;
      enc_pres_q  <= 1'b0;
      pos_q       <= '0;
      ver_start_q <= '0;
      ver_len_q   <= '0;
      enc_start_q <= '0;
      enc_len_q   <= '0;
      sd_q        <= xdr_pkg::SD_ABSENT;
    end else if (step_o) begin
      phase_q     <= phase_d;
      stage_q     <= stage_d;
      kw_sel_q    <= kw_sel_d;
      match_q     <= match_d;
      space_q     <= space_d;
      quote_dbl_q <= quote_dbl_d;
      digit_q     <= digit_d;
      ovf_q       <= ovf_d;
      ver_pres_q  <= ver_pres_d;
      enc_pres_q  <= enc_pres_d;
      pos_q       <= pos_d;
      ver_start_q <= ver_start_d;
      ver_len_q   <= ver_len_d;
      enc_start_q <= enc_start_d;
      enc_len_q   <= enc_len_d;
      sd_q        <= sd_d;
    end
  end

endmodule

// ----- rtl/core/xdr_out_reg.sv -----
// ----------------------------------------------------------------------------
// xdr_out_reg
// Result register: holds one result until the receiver takes the transfer.
// ----------------------------------------------------------------------------
module xdr_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  xdr_pkg::result_t result_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic             free_o,
  output xdr_pkg::result_t result_o
);

  logic             valid_q, valid_d;
  xdr_pkg::result_t result_q;

  assign free_o  = ~valid_q | ~out_stall_i;
  assign valid_d = load_i | (valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

// ----- rtl/core/xml_declaration_recognizer.sv -----
// ----------------------------------------------------------------------------
// xml_declaration_recognizer
// Streaming recognizer for an XML or text declaration, one character a cycle.
// ----------------------------------------------------------------------------
// Characters arrive on the input channel (in_valid_i / in_stall_o), one
// decoded code point per transfer with end-of-input and fault flags. A
// transfer completes when valid is high and stall is low. Each declaration
// yields exactly one result transfer on the output channel (out_valid_o /
// out_stall_i), at its closing '>' or at the first error; characters that
// cause no result produce nothing.
// Throughput is one character per cycle unless a result waits on a full
// result register: the parser state machine makes one transition per cycle
// between the input register and the result register.
// The deciding character passes from the input register through the parser
// into the result register, which drives out_valid_o.
// When the receiver stalls, the result register holds its transfer; the
// parser keeps consuming characters that cause no result and stalls the
// input only when a second result would be needed.
// Reset clears the parser to await '<', drops both registers' valid bits and
// sets text_mode to 0. The user writes text_mode (cfg_valid_i / cfg_data_i,
// always ready) only while no declaration is in progress (not enforced).
// ----------------------------------------------------------------------------
module xml_declaration_recognizer #(
  parameter int unsigned POS_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [20:0] in_code_point_i,
  input  logic        in_end_of_input_i,
  input  logic        in_char_fault_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  out_status_o,
  output logic [15:0] out_version_start_o,
  output logic [15:0] out_version_span_o,
  output logic [15:0] out_encoding_start_o,
  output logic [15:0] out_encoding_span_o,
  output logic [1:0]  out_standalone_value_o,
  output logic [15:0] out_decl_length_o,
  output logic        out_length_overflow_o
);

  xdr_pkg::item_t   in_item, item;
  xdr_pkg::result_t result, out_result;
  logic             item_valid, step, emit, out_free, load;

  assign cfg_ready_o = 1'b1;

  assign in_item.code_point   = in_code_point_i;
  assign in_item.end_of_input = in_end_of_input_i;
  assign in_item.char_fault   = in_char_fault_i;

  xdr_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item),
    .consume_i    (step),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  xdr_parse #(
    .POS_BITS (POS_BITS)
  ) u_parse (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_text_mode_i (cfg_data_i),
    .item_valid_i    (item_valid),
    .item_i          (item),
    .out_free_i      (out_free),
    .step_o          (step),
    .emit_o          (emit),
    .result_o        (result)
  );

  assign load = step & emit;

  xdr_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .result_i    (result),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .free_o      (out_free),
    .result_o    (out_result)
  );

  assign out_status_o           = out_result.status;
  assign out_version_start_o    = out_result.version_start;
  assign out_version_span_o     = out_result.version_span;
  assign out_encoding_start_o   = out_result.encoding_start;
  assign out_encoding_span_o    = out_result.encoding_span;
  assign out_standalone_value_o = out_result.standalone_value;
  assign out_decl_length_o      = out_result.decl_length;
  assign out_length_overflow_o  = out_result.length_overflow;

endmodule
